FILE: design/ccc_pkg.sv
// Package: widths, register indexes and pipeline payload types of the cycle count converter.
package ccc_pkg;

  localparam int VALUE_W   = 64;
  localparam int MULT_W    = 32;
  localparam int SHIFT_W   = 5;
  localparam int CFG_IDX_W = 2;
  // Widest dividend of a reverse request: a 64-bit difference shifted by up to 31.
  localparam int DQ_W      = VALUE_W + (2 ** SHIFT_W) - 1;
  // One divider cell per dividend bit.
  localparam int DIV_STEPS = DQ_W;
  // Full counter-times-multiplier product.
  localparam int PROD_W    = VALUE_W + MULT_W;
  localparam int PP_W      = 2 * MULT_W;

  localparam logic REQ_TO_TIME = 1'b0;
  localparam logic REQ_TO_CNT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT   = 2'd0,
    REG_SHIFT  = 2'd1,
    REG_OFFSET = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [MULT_W-1:0]  mult;
    logic [SHIFT_W-1:0] shift;
    logic [VALUE_W-1:0] offset;
  } cfg_t;

  // After the first front stage: partial products, or the offset-corrected time.
  typedef struct packed {
    logic              rev;
    logic [PP_W-1:0]   a;
    logic [PP_W-1:0]   b;
  } s1_t;

  // After the second front stage: full product, or the shifted dividend.
  typedef struct packed {
    logic              rev;
    logic [PROD_W-1:0] p;
  } s2_t;

  // Payload handed from cell to cell.
  typedef struct packed {
    logic              rev;
    logic [MULT_W-1:0] rem;
    logic [DQ_W-1:0]   dq;
  } cell_t;

endpackage

FILE: design/ccc_if.sv
// Interfaces: request, result and register-write channels of the cycle count converter.
interface ccc_in_if;
  import ccc_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [VALUE_W-1:0] in_value;
  modport source (output valid, output req_type, output in_value, input ready);
  modport sink   (input valid, input req_type, input in_value, output ready);
endinterface

interface ccc_out_if;
  import ccc_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] out_value;
  modport source (output valid, output out_value, input ready);
  modport sink   (input valid, input out_value, output ready);
endinterface

interface ccc_cfg_if;
  import ccc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VALUE_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/ccc_front.sv
// Front end: three stages that multiply, shift and add the offset, or remove the offset and align the dividend.
module ccc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  ccc_pkg::cfg_t                cfg,
  input  logic                         in_vld,
  input  logic                         in_req_type,
  input  logic [ccc_pkg::VALUE_W-1:0]  in_value,
  output logic                         in_rdy,
  input  logic                         nxt_vld,
  output logic                         vld,
  output ccc_pkg::cell_t               dat
);
  import ccc_pkg::*;

  logic  s1_vld_r, s1_vld_nxt, s2_vld_r, s2_vld_nxt, s3_vld_r, s3_vld_nxt;
  logic  s1_load, s2_load, s3_load;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  cell_t s3_r, s3_nxt;
  logic [PROD_W-1:0]  prod_sh;
  logic [DQ_W-1:0]    dvd;

  // A stage loads when the pipe moves or when it is empty; a stalled stage
  // empties itself when its successor takes the request.
  assign s1_load = adv || !s1_vld_r;
  assign s2_load = adv || !s2_vld_r;
  assign s3_load = adv || !s3_vld_r;
  assign in_rdy  = s1_load;

  assign s1_vld_nxt = s1_load ? in_vld   : s2_vld_r;
  assign s2_vld_nxt = s2_load ? s1_vld_r : s3_vld_r;
  assign s3_vld_nxt = s3_load ? s2_vld_r : nxt_vld;

  always_comb begin
    s1_nxt.rev = (in_req_type == REQ_TO_CNT);
    if (s1_nxt.rev) begin
      s1_nxt.a = in_value - cfg.offset;
      s1_nxt.b = '0;
    end else begin
      s1_nxt.a = PP_W'(in_value[MULT_W-1:0]) * PP_W'(cfg.mult);
      s1_nxt.b = PP_W'(in_value[VALUE_W-1:MULT_W]) * PP_W'(cfg.mult);
    end
  end

  always_comb begin
    dvd        = DQ_W'(s1_r.a) << cfg.shift;
    s2_nxt.rev = s1_r.rev;
    if (s1_r.rev) begin
      s2_nxt.p = PROD_W'(dvd);
    end else begin
      s2_nxt.p = PROD_W'(s1_r.a) + {s1_r.b, {MULT_W{1'b0}}};
    end
  end

  always_comb begin
    prod_sh    = s2_r.p >> cfg.shift;
    s3_nxt.rev = s2_r.rev;
    s3_nxt.rem = '0;
    if (s2_r.rev) begin
      s3_nxt.dq = s2_r.p[DQ_W-1:0];
    end else begin
      s3_nxt.dq = DQ_W'(cfg.offset + prod_sh[VALUE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      s3_vld_r <= s3_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= s1_nxt;
    end
    if (s2_load) begin
      s2_r <= s2_nxt;
    end
    if (s3_load) begin
      s3_r <= s3_nxt;
    end
  end

  assign vld = s3_vld_r;
  assign dat = s3_r;

endmodule

FILE: design/ccc_div_cell.sv
// Divider cell: one restoring-division step per cell, forward requests pass through.
module ccc_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [ccc_pkg::MULT_W-1:0]  divisor,
  input  logic                        prv_vld,
  input  ccc_pkg::cell_t              prv_dat,
  input  logic                        nxt_vld,
  output logic                        vld,
  output ccc_pkg::cell_t              dat
);
  import ccc_pkg::*;

  logic              vld_r, vld_nxt, load;
  cell_t             dat_r, dat_nxt;
  logic [MULT_W:0]   trial, diff;
  logic              ge;

  assign load    = adv || !vld_r;
  assign vld_nxt = load ? prv_vld : nxt_vld;

  // The partial remainder stays below the divisor, so one compare and
  // subtract per dividend bit is enough.
  always_comb begin
    trial       = {prv_dat.rem, prv_dat.dq[DQ_W-1]};
    diff        = trial - {1'b0, divisor};
    ge          = (trial >= {1'b0, divisor});
    dat_nxt     = prv_dat;
    if (prv_dat.rev) begin
      dat_nxt.rem = ge ? diff[MULT_W-1:0] : trial[MULT_W-1:0];
      dat_nxt.dq  = {prv_dat.dq[DQ_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld = vld_r;
  assign dat = dat_r;

endmodule

FILE: design/cycle_count_time_converter_unit.sv
// Top level: cycle counter to trace time converter, front end plus a chain of divider cells.
//
//   channel  | modport | payload                  | direction
//   ---------+---------+--------------------------+-----------
//   in_chan  | sink    | req_type, in_value       | request in
//   out_chan | source  | out_value                | result out
//   cfg_chan | sink    | index, data              | register write in
//
// An accepted request reaches its result through three front stages, one
// divider cell for each of the 95 dividend bits, and the output register.
// One request is accepted every cycle while the pipeline moves; the row of divider
// cells sets the latency and every request, forward or reverse, walks the same row.
// Reset (synchronous, active low) empties the pipeline and restores the
// multiplier to 1, the shift to 0 and the offset to 0.
// While the output is stalled, requests are still taken until the pipeline
// is full; each stage collapses a bubble in front of it once per cycle.
module cycle_count_time_converter_unit (
  input logic       clk,
  input logic       rst_n,
  ccc_in_if.sink    in_chan,
  ccc_out_if.source out_chan,
  ccc_cfg_if.sink   cfg_chan
);
  import ccc_pkg::*;

  // Configuration registers. A write of zero to the multiplier is dropped so
  // the divider never sees a zero divisor; writes to unknown indexes do nothing.
  logic [MULT_W-1:0]  mult_r, mult_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [VALUE_W-1:0] offset_r, offset_nxt;
  cfg_t               cfg;

  // Handshake chain: index 0 is the front end, index k+1 is divider cell k.
  logic               chain_vld [0:DIV_STEPS];
  cell_t              chain_dat [0:DIV_STEPS];

  // Output register that decouples the pipeline from the consumer.
  logic               out_vld_r, out_vld_nxt;
  logic [VALUE_W-1:0] out_value_r;
  logic               adv;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    mult_nxt   = mult_r;
    shift_nxt  = shift_r;
    offset_nxt = offset_r;
    if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_MULT: begin
          if (cfg_chan.data[MULT_W-1:0] != '0) begin
            mult_nxt = cfg_chan.data[MULT_W-1:0];
          end
        end
        REG_SHIFT: begin
          shift_nxt = cfg_chan.data[SHIFT_W-1:0];
        end
        REG_OFFSET: begin
          offset_nxt = cfg_chan.data;
        end
        default: begin
          mult_nxt = mult_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r   <= MULT_W'(1);
      shift_r  <= '0;
      offset_r <= '0;
    end else begin
      mult_r   <= mult_nxt;
      shift_r  <= shift_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign cfg.mult   = mult_r;
  assign cfg.shift  = shift_r;
  assign cfg.offset = offset_r;

  // The whole pipeline moves whenever the output register is free or drained.
  assign adv = !out_vld_r || out_chan.ready;

  // Front end: the forward request is finished here; the reverse request
  // leaves as the shifted difference (time - offset) << shift, ready to divide.
  ccc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .cfg         (cfg),
    .in_vld      (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_value    (in_chan.in_value),
    .in_rdy      (in_chan.ready),
    .nxt_vld     (chain_vld[1]),
    .vld         (chain_vld[0]),
    .dat         (chain_dat[0])
  );

  // Each cell brings one more dividend bit into the remainder and emits one
  // quotient bit. After the last cell the low 64 quotient bits are
  // (q << shift) + ((r << shift) / mult), wrapped, for the reverse request.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    logic nxt_vld;
    if (k == DIV_STEPS - 1) begin : g_last
      assign nxt_vld = out_vld_r;
    end else begin : g_mid
      assign nxt_vld = chain_vld[k+2];
    end

    ccc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .divisor (mult_r),
      .prv_vld (chain_vld[k]),
      .prv_dat (chain_dat[k]),
      .nxt_vld (nxt_vld),
      .vld     (chain_vld[k+1]),
      .dat     (chain_dat[k+1])
    );
  end

  assign out_vld_nxt = adv ? chain_vld[DIV_STEPS] : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= chain_dat[DIV_STEPS].dq[VALUE_W-1:0];
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.out_value = out_value_r;

endmodule

FILE: dv/cycle_count_time_converter_unit_tb.sv
// Testbench for the cycle count converter: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module cycle_count_time_converter_unit_tb;
  import ccc_pkg::*;

  // Writes to this index fall outside the register file and must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam int LATENCY       = 99;
  localparam int TAIL_CYCLES   = LATENCY + 40;
  localparam int LIMIT_CYCLES  = 400_000;
  localparam int RANDOM_PHASES = 9;
  localparam int PER_PHASE     = 100;

  logic clk;
  logic rst_n;

  ccc_in_if  in_chan ();
  ccc_out_if out_chan ();
  ccc_cfg_if cfg_chan ();

  cycle_count_time_converter_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_chan (cfg_chan.sink)
  );

  // One line of the directed plan: either a register write or a request. A typed-in
  // expectation is used only where the answer is obvious by inspection.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic                 req_type;
    logic [VALUE_W-1:0]   value;
    bit                   has_exp;
    logic [VALUE_W-1:0]   exp_value;
  } plan_row_t;

  plan_row_t          plan[$];
  // Converted values still owed by the block, oldest first.
  logic [VALUE_W-1:0] awaited_values[$];

  // Private copy of the register file, updated when a write is accepted.
  logic [MULT_W-1:0]  cur_mult;
  logic [SHIFT_W-1:0] cur_shift;
  logic [VALUE_W-1:0] cur_offset;

  int                 mismatches;
  int                 cycles;
  // When set, neither side idles, so the pipeline runs back to back.
  bit                 steady;
  logic [VALUE_W-1:0] got_value;

  always #6 clk = ~clk;

  // Forward direction: split the count at the shift so that the low fraction times
  // the multiplier stays exact, while the high part product wraps modulo 2^64.
  function automatic logic [VALUE_W-1:0] trace_time_of_count(input logic [VALUE_W-1:0] cnt);
    logic [VALUE_W-1:0] m;
    logic [VALUE_W-1:0] hi;
    logic [VALUE_W-1:0] lo;
    m  = {32'd0, cur_mult};
    hi = cnt >> cur_shift;
    lo = cnt & ((64'd1 << cur_shift) - 64'd1);
    return cur_offset + hi * m + ((lo * m) >> cur_shift);
  endfunction

  // Reverse direction: remove the offset (wrapping), divide, then rebuild the count
  // from the shifted quotient plus the scaled remainder.
  function automatic logic [VALUE_W-1:0] count_of_trace_time(input logic [VALUE_W-1:0] t);
    logic [VALUE_W-1:0] m;
    logic [VALUE_W-1:0] d;
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] r;
    m = {32'd0, cur_mult};
    d = t - cur_offset;
    q = d / m;
    r = d % m;
    return (q << cur_shift) + ((r << cur_shift) / m);
  endfunction

  // A zero multiplier is refused, and only the low bits of each register are kept.
  function automatic void note_register_write(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [VALUE_W-1:0] data);
    case (idx)
      REG_MULT: begin
        if (data[MULT_W-1:0] != '0) cur_mult = data[MULT_W-1:0];
      end
      REG_SHIFT: begin
        cur_shift = data[SHIFT_W-1:0];
      end
      REG_OFFSET: begin
        cur_offset = data;
      end
      default: begin
      end
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values are biased toward the corners and toward the current offset, where the
  // reverse difference is small or wraps around.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 1000));
      3: return cur_offset + 64'($urandom_range(0, 100000));
      4: return cur_offset - 64'($urandom_range(1, 100000));
      5: return {32'd0, 32'($urandom)};
      6: return 64'd1 << $urandom_range(0, 63);
      7: return cur_offset + ({32'($urandom), 32'($urandom)} >> $urandom_range(0, 63));
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic void add_req(input logic rt, input logic [VALUE_W-1:0] v,
                                  input bit has_exp = 0,
                                  input logic [VALUE_W-1:0] exp_v = '0);
    plan_row_t row;
    row = '{is_cfg: 0, idx: '0, req_type: rt, value: v, has_exp: has_exp, exp_value: exp_v};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VALUE_W-1:0] data);
    plan_row_t row;
    row = '{is_cfg: 1, idx: idx, req_type: 0, value: data, has_exp: 0, exp_value: '0};
    plan.push_back(row);
  endfunction

  // Called at a falling edge. The request valid is left high on return so that a
  // request following immediately is not lowered and raised in the same step; the
  // caller lowers it before time moves on.
  task automatic send_request(input logic rt, input logic [VALUE_W-1:0] v,
                              input bit has_exp, input logic [VALUE_W-1:0] exp_v);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= rt;
    in_chan.in_value <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    // Accepted at this edge; the configuration cannot change while work is in flight.
    if (has_exp) begin
      awaited_values.push_back(exp_v);
    end else if (rt == REQ_TO_TIME) begin
      awaited_values.push_back(trace_time_of_count(v));
    end else begin
      awaited_values.push_back(count_of_trace_time(v));
    end
    @(negedge clk);
  endtask

  // Registers change only with the pipeline empty. Since every request yields exactly
  // one result, an empty list of owed values means nothing is left inside the block.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [VALUE_W-1:0] data);
    in_chan.valid <= 1'b0;
    while (awaited_values.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    note_register_write(idx, data);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  // A fresh setting for one random phase, with random bits above the multiplier and
  // shift widths, and now and then a refused zero multiplier or a write to no register.
  task automatic new_settings();
    logic [MULT_W-1:0]  m;
    logic [VALUE_W-1:0] data;
    case ($urandom_range(0, 4))
      0: m = 32'd1;
      1: m = 32'hFFFF_FFFF;
      2: m = 32'($urandom_range(1, 255));
      3: m = 32'd1 << $urandom_range(0, 31);
      default: m = 32'($urandom);
    endcase
    write_register(REG_MULT, {32'($urandom), m});
    data = {32'($urandom), 32'($urandom)};
    case ($urandom_range(0, 3))
      0: data[SHIFT_W-1:0] = 5'd0;
      1: data[SHIFT_W-1:0] = 5'd31;
      default: data[SHIFT_W-1:0] = 5'($urandom_range(0, 31));
    endcase
    write_register(REG_SHIFT, data);
    case ($urandom_range(0, 3))
      0: data = '0;
      1: data = '1;
      2: data = {32'd0, 32'($urandom)};
      default: data = {32'($urandom), 32'($urandom)};
    endcase
    write_register(REG_OFFSET, data);
    if ($urandom_range(0, 3) == 0) write_register(REG_MULT, {32'($urandom), 32'd0});
    if ($urandom_range(0, 3) == 0) write_register(REG_NONE, {32'($urandom), 32'($urandom)});
  endtask

  // Result side: stalls of random length separated by random runs of readiness.
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    forever begin
      stall = gap_cycles();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // Every accepted result is matched against the oldest value still owed.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (awaited_values.size() == 0) begin
        $error("out_value: no result expected, actual %h", out_chan.out_value);
        mismatches++;
      end else begin
        got_value = awaited_values.pop_front();
        if (out_chan.out_value !== got_value) begin
          $error("out_value mismatch: expected %h, actual %h", got_value, out_chan.out_value);
          mismatches++;
        end
      end
    end
  end

  // Hard stop in case the block hangs on a handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("cycle_count_time_converter_unit regression: fail");
      $finish;
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.req_type = REQ_TO_TIME;
    in_chan.in_value = '0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.index   = REG_MULT;
    cfg_chan.data    = '0;
    mismatches       = 0;
    cycles           = 0;
    steady           = 0;
    cur_mult         = 32'd1;
    cur_shift        = '0;
    cur_offset       = '0;

    // Reset values make both directions the identity.
    add_req(REQ_TO_TIME, 64'd0, 1, 64'd0);
    add_req(REQ_TO_TIME, '1, 1, '1);
    add_req(REQ_TO_CNT, 64'd0, 1, 64'd0);
    add_req(REQ_TO_CNT, '1, 1, '1);
    // A zero multiplier, also one hidden under nonzero upper bits, is refused, and a
    // write to no register does nothing, so the identity must still hold.
    add_cfg(REG_MULT, 64'd0);
    add_cfg(REG_MULT, 64'hFFFF_FFFF_0000_0000);
    add_cfg(REG_NONE, '1);
    add_req(REQ_TO_TIME, 64'h0123_4567_89AB_CDEF, 1, 64'h0123_4567_89AB_CDEF);
    add_req(REQ_TO_CNT, 64'hFEDC_BA98_7654_3210, 1, 64'hFEDC_BA98_7654_3210);
    // All registers at their maximum.
    add_cfg(REG_MULT, 64'h0000_0000_FFFF_FFFF);
    add_cfg(REG_SHIFT, 64'd31);
    add_cfg(REG_OFFSET, '1);
    add_req(REQ_TO_TIME, 64'd0, 1, '1);
    add_req(REQ_TO_CNT, '1, 1, 64'd0);
    add_req(REQ_TO_TIME, '1);
    add_req(REQ_TO_CNT, 64'd0);
    add_req(REQ_TO_CNT, 64'h8000_0000_0000_0000);
    // Wide writes keep only the low bits: multiplier 1, shift 31.
    add_cfg(REG_MULT, 64'hABCD_0000_0000_0001);
    add_cfg(REG_SHIFT, 64'h1234_5678_9ABC_DEFF);
    add_cfg(REG_OFFSET, 64'd0);
    add_req(REQ_TO_CNT, 64'd1, 1, 64'h8000_0000);
    add_req(REQ_TO_TIME, 64'h8000_0000, 1, 64'd1);
    add_req(REQ_TO_TIME, 64'h7FFF_FFFF, 1, 64'd0);
    add_req(REQ_TO_CNT, '1);
    // Small odd multiplier with a real fraction and an offset below which times wrap.
    add_cfg(REG_MULT, 64'h5A5A_5A5A_0000_0003);
    add_cfg(REG_SHIFT, 64'hE5);
    add_cfg(REG_OFFSET, 64'h0000_1000_0000_0000);
    add_req(REQ_TO_TIME, 64'h1F);
    add_req(REQ_TO_TIME, '1);
    add_req(REQ_TO_CNT, 64'h0000_1000_0000_0000, 1, 64'd0);
    add_req(REQ_TO_CNT, 64'h0000_0FFF_FFFF_FFFF);
    add_req(REQ_TO_CNT, '1);
    add_cfg(REG_MULT, 64'h8000_0000);
    add_cfg(REG_SHIFT, 64'd0);
    add_cfg(REG_OFFSET, 64'd1);
    add_req(REQ_TO_TIME, '1);
    add_req(REQ_TO_CNT, 64'd0);
    add_req(REQ_TO_TIME, 64'd1);
    add_req(REQ_TO_CNT, 64'h8000_0000);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_register(plan[i].idx, plan[i].value);
      end else begin
        send_request(plan[i].req_type, plan[i].value, plan[i].has_exp, plan[i].exp_value);
      end
    end

    // Random phases, each under its own register setting; some run without idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = 0;
      new_settings();
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PER_PHASE; k++) begin
        send_request(1'($urandom_range(0, 1)), pick_value(), 0, '0);
      end
    end
    in_chan.valid <= 1'b0;
    steady = 0;

    while (awaited_values.size() != 0) @(posedge clk);
    // Any result beyond this point would be unexpected and flagged by the checker.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("cycle_count_time_converter_unit regression: pass");
    end else begin
      $display("cycle_count_time_converter_unit regression: fail");
    end
    $finish;
  end

endmodule
